@@ hw/rtl/sha1_pkg.sv @@
`timescale 1ns / 1ps

package sha1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } wv_t;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] RND_LAST   = 7'd79;
  localparam logic [6:0] RND_END_R0 = 7'd20;
  localparam logic [6:0] RND_END_R1 = 7'd40;
  localparam logic [6:0] RND_END_R2 = 7'd60;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [2:0] WORD_LAST  = 3'd4;
  localparam logic [2:0] LEN_LAST   = 3'd7;

endpackage

@@ hw/rtl/sha1_round.sv @@
`timescale 1ns / 1ps

module sha1_round (
  input  sha1_pkg::wv_t  cur_i,
  input  logic [31:0]    w_i,
  input  logic [6:0]     rnd_i,
  output sha1_pkg::wv_t  nxt_o
);
  import sha1_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  always_comb begin
    if (rnd_i < RND_END_R0) begin
      f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      k = K_R0;
    end else if (rnd_i < RND_END_R1) begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = K_R1;
    end else if (rnd_i < RND_END_R2) begin
      f = (cur_i.b & cur_i.c) | (cur_i.b & cur_i.d) | (cur_i.c & cur_i.d);
      k = K_R2;
    end else begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = K_R3;
    end
  end

  assign tmp = {cur_i.a[26:0], cur_i.a[31:27]} + f + cur_i.e + k + w_i;

  always_comb begin
    nxt_o.a = tmp;
    nxt_o.b = cur_i.a;
    nxt_o.c = {cur_i.b[1:0], cur_i.b[31:2]};
    nxt_o.d = cur_i.c;
    nxt_o.e = cur_i.d;
  end

endmodule

@@ hw/rtl/sha1_digest_engine.sv @@
`timescale 1ns / 1ps
// SHA-1 digest over a byte stream.
// Input channel: in_valid_i / in_stall_o with in_data_i carrying one optional
// message byte and an end-of-message flag. Output channel: out_valid_o /
// out_stall_i with out_data_o carrying one digest word, its index and a last
// flag; five transactions per ended message, h0 first.
// A byte transaction is accepted in the idle state. The transaction that completes a
// 64-byte block holds the input while the 80 rounds run on the single round
// unit, one round per cycle, and then while the result is added into the chaining words.
// At message end the padding bytes pass through the same byte path one per
// cycle (up to 72 bytes), with one or two block compressions in between, then
// the five digest words are offered, one per cycle when not
// stalled. The input stays stalled until the last word is taken.
// A stalled output word holds; the engine waits in that state.
// Reset loads the standard initial chaining values, clears the byte fill and
// bit length and returns to the idle state, ready for input.

module sha1_digest_engine #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sha1_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sha1_pkg::out_t   out_data_o
);
  import sha1_pkg::*;

  state_e state_q, state_d;
  logic [511:0] blk_q, blk_d;
  logic [5:0]   fill_q, fill_d;
  logic [LENGTH_COUNTER_BITS-1:0] bits_q, bits_d;
  logic [31:0]  chain_q [5];
  logic [31:0]  chain_d [5];
  wv_t          wv_q, wv_d, wv_rnd;
  logic [6:0]   rnd_q, rnd_d;
  logic         msg_end_q, msg_end_d;
  logic         pad_first_q, pad_first_d;
  logic         len_phase_q, len_phase_d;
  logic [2:0]   len_idx_q, len_idx_d;
  logic         done_q, done_d;
  logic [2:0]   out_idx_q, out_idx_d;

  logic         ins_en;
  logic [7:0]   ins_byte;
  logic [63:0]  len64;
  logic [63:0]  len_shift;
  logic [31:0]  sched_x;
  logic [31:0]  sched_new;
  logic         in_acc;
  logic         out_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign out_data_o.digest_word = chain_q[out_idx_q];
  assign out_data_o.word_index  = out_idx_q;
  assign out_data_o.last_word   = (out_idx_q == WORD_LAST);

  assign len64     = 64'(bits_q);
  assign len_shift = len64 << {len_idx_q, 3'b000};
  assign sched_x   = blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64];
  assign sched_new = {sched_x[30:0], sched_x[31]};

  sha1_round u_round (
    .cur_i (wv_q),
    .w_i   (blk_q[511:480]),
    .rnd_i (rnd_q),
    .nxt_o (wv_rnd)
  );

  always_comb begin
    state_d     = state_q;
    blk_d       = blk_q;
    fill_d      = fill_q;
    bits_d      = bits_q;
    chain_d     = chain_q;
    wv_d        = wv_q;
    rnd_d       = rnd_q;
    msg_end_d   = msg_end_q;
    pad_first_d = pad_first_q;
    len_phase_d = len_phase_q;
    len_idx_d   = len_idx_q;
    done_d      = done_q;
    out_idx_d   = out_idx_q;
    ins_en      = 1'b0;
    ins_byte    = in_data_i.data_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.byte_present) begin
            ins_en = 1'b1;
            bits_d = bits_q + LENGTH_COUNTER_BITS'(8);
          end
          if (in_data_i.end_of_message) begin
            msg_end_d   = 1'b1;
            pad_first_d = 1'b1;
            state_d     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ins_en = 1'b1;
        if (pad_first_q) begin
          ins_byte    = PAD_BYTE;
          pad_first_d = 1'b0;
        end else if (!len_phase_q && fill_q != FILL_LEN) begin
          ins_byte = 8'h00;
        end else begin
          ins_byte    = len_shift[63:56];
          len_phase_d = 1'b1;
          len_idx_d   = len_idx_q + 3'd1;
          if (len_idx_q == LEN_LAST) begin
            done_d = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        wv_d  = wv_rnd;
        blk_d = {blk_q[479:0], sched_new};
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == RND_LAST) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        chain_d[0] = chain_q[0] + wv_q.a;
        chain_d[1] = chain_q[1] + wv_q.b;
        chain_d[2] = chain_q[2] + wv_q.c;
        chain_d[3] = chain_q[3] + wv_q.d;
        chain_d[4] = chain_q[4] + wv_q.e;
        rnd_d      = 7'd0;
        if (done_q) begin
          state_d = ST_OUT;
        end else if (msg_end_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (out_idx_q == WORD_LAST) begin
            chain_d     = H_INIT;
            fill_d      = 6'd0;
            bits_d      = '0;
            msg_end_d   = 1'b0;
            pad_first_d = 1'b0;
            len_phase_d = 1'b0;
            len_idx_d   = 3'd0;
            done_d      = 1'b0;
            out_idx_d   = 3'd0;
            state_d     = ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (ins_en) begin
      blk_d  = {blk_q[503:0], ins_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q == FILL_LAST) begin
        wv_d    = '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3], e: chain_q[4]};
        rnd_d   = 7'd0;
        state_d = ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= 6'd0;
      bits_q      <= '0;
      chain_q     <= H_INIT;
      rnd_q       <= 7'd0;
      msg_end_q   <= 1'b0;
      pad_first_q <= 1'b0;
      len_phase_q <= 1'b0;
      len_idx_q   <= 3'd0;
      done_q      <= 1'b0;
      out_idx_q   <= 3'd0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bits_q      <= bits_d;
      chain_q     <= chain_d;
      rnd_q       <= rnd_d;
      msg_end_q   <= msg_end_d;
      pad_first_q <= pad_first_d;
      len_phase_q <= len_phase_d;
      len_idx_q   <= len_idx_d;
      done_q      <= done_d;
      out_idx_q   <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    wv_q  <= wv_d;
  end

`ifndef SYNTHESIS
  a_no_input_during_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o
  ) else $error("input accepted while digest words are pending");

  a_last_word_ends_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.last_word |=> !out_valid_o && !in_stall_o
  ) else $error("output did not end after the last word");

  a_word_index_advances: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_data_o.last_word |=>
      out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1
  ) else $error("digest word index did not advance");

  a_rounds_then_final: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND && rnd_q == RND_LAST |=> state_q == ST_FINAL
  ) else $error("round sequence did not end in the chaining update");
`endif

endmodule
